// ===== rtl/gclc_pkg.sv =====
// ----------------------------------------------------------------------------
// gclc_pkg: shared types and constants for the G-code line classifier
// Item structs for the text and result channels, character codes and the
// phase encodings of the two line scanners.
// ----------------------------------------------------------------------------
package gclc_pkg;

  // Payload of one text item
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } text_item_t;

  // Payload of one result item
  typedef struct packed {
    logic extended_command;
    logic axis_word_without_value;
    logic line_filtered;
  } result_item_t;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOW_E = 8'h65;

  // Command word run length saturates here
  localparam logic [1:0] RUN_SAT = 2'd2;

  // Extended command scanner phase
  typedef enum logic [2:0] {
    CMD_LEAD = 3'b001,
    CMD_RUN  = 3'b010,
    CMD_DONE = 3'b100
  } cmd_phase_t;

  // Parameter word scanner phase
  typedef enum logic [5:0] {
    WRD_LEAD   = 6'b000001,
    WRD_DIGITS = 6'b000010,
    WRD_SCAN   = 6'b000100,
    WRD_LETTER = 6'b001000,
    WRD_NUMBER = 6'b010000,
    WRD_DONE   = 6'b100000
  } wrd_phase_t;

endpackage

// ===== rtl/gclc_if.sv =====
// ----------------------------------------------------------------------------
// gclc_if: valid/ready channels of the G-code line classifier
// One interface for the text byte channel, one for the result channel.
// ----------------------------------------------------------------------------
interface gclc_text_if import gclc_pkg::*; ();
  logic       valid;
  logic       ready;
  text_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gclc_result_if import gclc_pkg::*; ();
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/gcode_line_command_classifier.sv =====
// ----------------------------------------------------------------------------
// gcode_line_command_classifier: per-line G-code command tests
// Scans G-code text byte by byte and reports, at each line end, whether the
// line is an extended command word and whether an M/G line has a parameter
// letter without a value.
// ----------------------------------------------------------------------------
// Usage: send one text item per byte with line_end low, then one item with
// line_end high to close the line; that item yields one result item and
// clears the scan state. The block takes one item every cycle unless ready
// drops. A text item passes an input register and then the scan logic into
// the result register, which loads as the line-end item leaves the input
// register. Ready drops only while a line-end item sits in the input register
// and the result register still holds a result that has not been taken.
module gcode_line_command_classifier import gclc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gclc_text_if.sink     text,
  gclc_result_if.source result
);

  // Input register
  logic       s1_valid;
  text_item_t s1_item;
  logic       s1_go;

  // Scan state
  cmd_phase_t cmd_phase, cmd_phase_next;
  logic [1:0] run_len, run_len_next;
  logic       cmd_rej, cmd_rej_next;
  wrd_phase_t wrd_phase, wrd_phase_next;
  logic       wrd_miss, wrd_miss_next;

  // Result register
  logic         out_valid;
  result_item_t out_item;

  // Character classes of the byte in the input register
  logic [7:0] c;
  logic is_digit, is_upper, is_blank, is_param, is_value, is_cut, is_term;
  logic ext, miss;

  assign c        = s1_item.char_code;
  assign is_digit = (c >= CH_0) && (c <= CH_9);
  assign is_upper = (c >= CH_A) && (c <= CH_Z);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign is_param = (c == CH_E) || (c == CH_X) || (c == CH_Y) || (c == CH_Z) ||
                    (c == CH_F) || (c == CH_S) || (c == CH_P) || (c == CH_R) ||
                    (c == CH_T);
  assign is_value = is_digit || (c == CH_DOT) || (c == CH_MINUS) || (c == CH_PLUS);
  assign is_cut   = (c == CH_SEMI) || (c == CH_LPAR);
  assign is_term  = is_blank || (c == CH_CR) || (c == CH_LF) || (c == CH_EQ);

  // Input register advances unless a result is blocked behind a full output
  assign s1_go      = s1_valid && !(s1_item.line_end && out_valid && !result.ready);
  assign text.ready = !s1_valid || s1_go;

  // Line verdict from the current state
  always_comb begin
    case (cmd_phase)
      CMD_LEAD: ext = 1'b0;
      CMD_RUN:  ext = (run_len == RUN_SAT);
      CMD_DONE: ext = !cmd_rej;
      default:  ext = 1'b0;
    endcase
    miss = wrd_miss || (wrd_phase == WRD_LETTER);
  end

  // Extended command scanner
  always_comb begin
    cmd_phase_next = cmd_phase;
    run_len_next   = run_len;
    cmd_rej_next   = cmd_rej;
    case (cmd_phase)
      CMD_LEAD: begin
        if (!is_blank) begin
          if (is_upper) begin
            cmd_phase_next = CMD_RUN;
            run_len_next   = 2'd1;
          end else begin
            cmd_rej_next   = 1'b1;
            cmd_phase_next = CMD_DONE;
          end
        end
      end
      CMD_RUN: begin
        if (is_upper || (c == CH_UNDER)) begin
          if (run_len != RUN_SAT) run_len_next = run_len + 2'd1;
        end else begin
          if ((run_len != RUN_SAT) || !is_term) cmd_rej_next = 1'b1;
          cmd_phase_next = CMD_DONE;
        end
      end
      CMD_DONE: ;
      default: cmd_phase_next = CMD_DONE;
    endcase
  end

  // Parameter word scanner
  always_comb begin
    wrd_phase_next = wrd_phase;
    wrd_miss_next  = wrd_miss;
    if (wrd_phase != WRD_DONE) begin
      if (is_cut) begin
        if (wrd_phase == WRD_LETTER) wrd_miss_next = 1'b1;
        wrd_phase_next = WRD_DONE;
      end else begin
        case (wrd_phase)
          WRD_LEAD: begin
            if (!is_blank)
              wrd_phase_next = ((c == CH_M) || (c == CH_G)) ? WRD_DIGITS : WRD_DONE;
          end
          WRD_DIGITS: begin
            if (!is_digit) wrd_phase_next = is_param ? WRD_LETTER : WRD_SCAN;
          end
          WRD_LETTER: begin
            if (is_value) begin
              wrd_phase_next = WRD_NUMBER;
            end else begin
              wrd_miss_next  = 1'b1;
              wrd_phase_next = is_param ? WRD_LETTER : WRD_SCAN;
            end
          end
          WRD_NUMBER: begin
            if (!(is_value || (c == CH_LOW_E) || (c == CH_E)))
              wrd_phase_next = is_param ? WRD_LETTER : WRD_SCAN;
          end
          default: wrd_phase_next = is_param ? WRD_LETTER : WRD_SCAN;
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
    if (text.ready && text.valid) s1_item <= text.data;
  end

  // Scan state: byte items advance it, a line-end item clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_phase <= CMD_LEAD;
      run_len   <= 2'd0;
      cmd_rej   <= 1'b0;
      wrd_phase <= WRD_LEAD;
      wrd_miss  <= 1'b0;
    end else if (s1_go) begin
      if (s1_item.line_end) begin
        cmd_phase <= CMD_LEAD;
        run_len   <= 2'd0;
        cmd_rej   <= 1'b0;
        wrd_phase <= WRD_LEAD;
        wrd_miss  <= 1'b0;
      end else begin
        cmd_phase <= cmd_phase_next;
        run_len   <= run_len_next;
        cmd_rej   <= cmd_rej_next;
        wrd_phase <= wrd_phase_next;
        wrd_miss  <= wrd_miss_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.line_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_item.line_end) begin
      out_item.extended_command        <= ext;
      out_item.axis_word_without_value <= miss;
      out_item.line_filtered           <= ext | miss;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_item;

`ifndef SYNTH
  // A closed line leaves both scanners at their start
  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_item.line_end |=>
      (cmd_phase == CMD_LEAD) && (wrd_phase == WRD_LEAD) && !cmd_rej && !wrd_miss)
    else $error("scan state not cleared after line end");

  // A waiting result is never overwritten
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_item))
    else $error("pending result lost or changed");

  // A line end behind a blocked result stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_item.line_end && out_valid && !result.ready |-> !text.ready)
    else $error("input accepted while line end is blocked");
`endif

endmodule

// ===== bench/tb_gcode_line_command_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_gcode_line_command_classifier: self-checking bench for the line classifier
// Streams G-code text bytes and line-end items into the block with random
// gaps and result-side stalls. A scoreboard tracks both line scanners per
// accepted item and checks each result item against the line it closes.
// ----------------------------------------------------------------------------
module tb_gcode_line_command_classifier;
  import gclc_pkg::*;

  localparam int          REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_ITEMS = 1050;

  // Tracks both scanners over accepted text items, holds the due flags
  class line_flag_board;
    cmd_phase_t   cmd_phase;
    logic [1:0]   run_len;
    logic         cmd_rejected;
    wrd_phase_t   wrd_phase;
    logic         value_missing;
    result_item_t flags_due[$];
    int unsigned  failures;
    int unsigned  lines_checked;

    function new();
      clear_line();
      failures      = 0;
      lines_checked = 0;
    endfunction

    function void clear_line();
      cmd_phase     = CMD_LEAD;
      run_len       = '0;
      cmd_rejected  = 1'b0;
      wrd_phase     = WRD_LEAD;
      value_missing = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function bit is_upper(logic [7:0] c);
      return c >= CH_A && c <= CH_Z;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit starts_value(logic [7:0] c);
      return is_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS;
    endfunction

    // Phase after a byte that is not part of a value
    function wrd_phase_t word_start(logic [7:0] c);
      if (c == CH_E || c == CH_X || c == CH_Y || c == CH_Z || c == CH_F ||
          c == CH_S || c == CH_P || c == CH_R || c == CH_T) begin
        return WRD_LETTER;
      end
      return WRD_SCAN;
    endfunction

    // Extended command word scan
    function void scan_command(logic [7:0] c);
      case (cmd_phase)
        CMD_LEAD: begin
          if (!is_blank(c)) begin
            if (is_upper(c)) begin
              cmd_phase = CMD_RUN;
              run_len   = 2'd1;
            end else begin
              cmd_rejected = 1'b1;
              cmd_phase    = CMD_DONE;
            end
          end
        end
        CMD_RUN: begin
          if (is_upper(c) || c == CH_UNDER) begin
            if (run_len < RUN_SAT) run_len = run_len + 2'd1;
          end else begin
            if (run_len < RUN_SAT ||
                !(is_blank(c) || c == CH_CR || c == CH_LF || c == CH_EQ)) begin
              cmd_rejected = 1'b1;
            end
            cmd_phase = CMD_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    // Parameter word scan; ';' or '(' cuts the line short
    function void scan_word(logic [7:0] c);
      if (wrd_phase == WRD_DONE) return;
      if (c == CH_SEMI || c == CH_LPAR) begin
        if (wrd_phase == WRD_LETTER) value_missing = 1'b1;
        wrd_phase = WRD_DONE;
        return;
      end
      case (wrd_phase)
        WRD_LEAD: begin
          if (!is_blank(c)) wrd_phase = (c == CH_M || c == CH_G) ? WRD_DIGITS : WRD_DONE;
        end
        WRD_DIGITS: begin
          if (!is_digit(c)) wrd_phase = word_start(c);
        end
        WRD_LETTER: begin
          if (starts_value(c)) begin
            wrd_phase = WRD_NUMBER;
          end else begin
            value_missing = 1'b1;
            wrd_phase     = word_start(c);
          end
        end
        WRD_NUMBER: begin
          if (!(starts_value(c) || c == CH_LOW_E || c == CH_E)) wrd_phase = word_start(c);
        end
        default: wrd_phase = word_start(c);
      endcase
    endfunction

    // Accepted text item: advance the scan, or close the line
    function void note_text(text_item_t item);
      result_item_t due;
      logic         ext;
      logic         miss;
      if (!item.line_end) begin
        scan_command(item.char_code);
        scan_word(item.char_code);
        return;
      end
      case (cmd_phase)
        CMD_LEAD: ext = 1'b0;
        CMD_RUN:  ext = (run_len >= RUN_SAT);
        default:  ext = !cmd_rejected;
      endcase
      miss = value_missing || wrd_phase == WRD_LETTER;
      due.extended_command        = ext;
      due.axis_word_without_value = miss;
      due.line_filtered           = ext | miss;
      flags_due = {flags_due, due};
      clear_line();
    endfunction

    // Accepted result item against the oldest closed line
    function void check_flags(result_item_t got);
      result_item_t due;
      if (flags_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("unexpected result: ext=%b axis=%b filt=%b",
                   got.extended_command, got.axis_word_without_value, got.line_filtered);
        end
        return;
      end
      due = flags_due.pop_front();
      lines_checked++;
      if (got.extended_command !== due.extended_command ||
          got.axis_word_without_value !== due.axis_word_without_value ||
          got.line_filtered !== due.line_filtered) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("line %0d: expected ext=%b axis=%b filt=%b, got ext=%b axis=%b filt=%b",
                   lines_checked, due.extended_command, due.axis_word_without_value,
                   due.line_filtered, got.extended_command, got.axis_word_without_value,
                   got.line_filtered);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  gclc_text_if   text_ch ();
  gclc_result_if result_ch ();

  gcode_line_command_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  line_flag_board board;
  logic [7:0]     line_buf[$];
  int unsigned    sent_count;
  bit             steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous run limit
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Gap length: mostly none or short, a few long; none in steady stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Append one byte to the line being built
  function automatic void put_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  function automatic void add_text(int unsigned n);
    repeat (n) put_byte(8'($urandom_range(32, 126)));
  endfunction

  // Numeric value, possibly empty, with sign, fraction and exponent
  function automatic void add_number();
    if ($urandom_range(0, 3) == 0) put_byte(pick("-+"));
    repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
    if ($urandom_range(0, 2) == 0) begin
      put_byte(CH_DOT);
      repeat ($urandom_range(0, 2)) put_byte(pick("0123456789"));
    end
    if ($urandom_range(0, 7) == 0) begin
      put_byte(pick("eE"));
      put_byte(pick("-0123456789"));
    end
  endfunction

  // M/G line with parameter words and an optional trailing comment
  function automatic void build_motion_line();
    put_byte(pick("MG"));
    repeat ($urandom_range(0, 3)) put_byte(pick("0123456789"));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) != 0) put_byte(pick(" \t"));
      put_byte(($urandom_range(0, 3) != 0) ? pick("EXYZFSPRT") :
                                              pick("ABCDGHIJKLMNOQUVWxyz"));
      if ($urandom_range(0, 4) != 0) add_number();
    end
    if ($urandom_range(0, 3) == 0) begin
      put_byte(pick(";("));
      add_text($urandom_range(0, 6));
    end
  endfunction

  // Uppercase word run with assorted terminators
  function automatic void build_word_line();
    logic [7:0] stops[5];
    stops = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_EQ};
    put_byte(pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
    repeat ($urandom_range(0, 5)) put_byte(pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
    case ($urandom_range(0, 3))
      0: ;
      1, 2: begin
        put_byte(stops[$urandom_range(0, 4)]);
        add_text($urandom_range(0, 5));
      end
      default: begin
        put_byte(8'($urandom_range(0, 255)));
        add_text($urandom_range(0, 3));
      end
    endcase
  endfunction

  // Comment lines, empty lines, lowercase and other odd shapes
  function automatic void build_odd_line();
    case ($urandom_range(0, 4))
      0: begin
        put_byte(pick(";("));
        add_text($urandom_range(0, 6));
      end
      1: ;
      2: begin
        put_byte(pick("gmxe_"));
        add_text($urandom_range(0, 4));
      end
      3: begin
        put_byte(pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        put_byte(pick("0123456789 "));
        add_text($urandom_range(0, 4));
      end
      default: begin
        put_byte(pick("MG"));
        put_byte(CH_SPACE);
        put_byte(pick("EXYZFSPRT"));
      end
    endcase
  endfunction

  function automatic void build_line();
    int unsigned kind;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte(pick(" \t"));
    if (kind < 40) build_motion_line();
    else if (kind < 65) build_word_line();
    else if (kind < 80) repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(0, 255)));
    else build_odd_line();
  endfunction

  // One text item; called and returns at a falling edge
  task automatic send_item(input logic [7:0] c, input logic eol);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      text_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid = 1'b1;
    text_ch.data  = {c, eol};
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s, input logic [7:0] end_char);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(end_char, 1'b1);
  endtask

  // Result side stalls
  initial begin : result_stall
    int unsigned hold;
    result_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      result_ch.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      hold = pick_gap();
      if (hold != 0) begin
        result_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) board.note_text(text_ch.data);
      if (result_ch.valid && result_ch.ready) board.check_flags(result_ch.data);
    end
  end

  initial begin : stimulus
    board           = new();
    steady          = 1'b0;
    sent_count      = 0;
    rst             = 1'b1;
    text_ch.valid   = 1'b0;
    text_ch.data    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lines: empty, blank, letter cut by comment, LF inside a word,
    // comment first, top byte, lowercase, value with sign after E
    send_item(8'hFF, 1'b1);
    send_text(" \t", 8'h00);
    send_text("GX;", 8'h5A);
    send_text("AB\n", 8'h01);
    send_text("(", 8'hFE);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_text("Ab", 8'h7F);
    send_text("M1E-", 8'h3B);

    // Random lines, with occasional stretches of no idling
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      build_line();
      foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    text_ch.valid = 1'b0;
    steady        = 1'b0;

    // Drain, then keep watching for anything stray before the verdict
    while (board.flags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.flags_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
